/* design/assert_macros.svh */
// Assertion macros shared by the snippet fragment selector RTL.
// Needs nothing else; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");

// A consequence that must hold in the same cycle as its antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");

`endif

/* design/sfs_pkg.sv */
// Package for the snippet fragment selector: widths, register codes and
// the fragment request record passed from the front end to the back end.
`default_nettype none

package sfs_pkg;

  // Sizing of the word window, byte offsets and weights.
  localparam int WINDOW_DEPTH     = 16;
  localparam int OFFSET_BITS      = 31;
  localparam int WEIGHT_FRAC_BITS = 16;

  localparam int POS_W    = 32;
  localparam int TERM_W   = 16;
  localparam int WEIGHT_W = 24;
  localparam int FW_W     = 27;
  localparam int TOTAL_W  = 32;
  localparam int CTX_W    = 4;

  // Window and counter widths.
  localparam int WIN_IDX_W = $clog2(WINDOW_DEPTH);
  localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
  localparam int WREM_W    = CTX_W + 1;
  localparam int KEEP_W    = (FILL_W > WREM_W) ? FILL_W : WREM_W;

  // Highlight zones and fragment extensions.
  localparam int ZONE_MAX = 5;
  localparam int ZC_W     = $clog2(ZONE_MAX + 1);
  localparam int EXT_W    = 3;
  localparam logic [EXT_W-1:0] EXT_LIMIT = EXT_W'(3);

  // Depth of the queue between the front and back ends.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTEXT_WORDS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LIMIT   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT    = CFG_IDX_W'(2);

  // Reset values of the configuration registers.
  localparam logic [CTX_W-1:0]   CONTEXT_RESET = CTX_W'(4);
  localparam logic [TOTAL_W-1:0] LIMIT_RESET   = TOTAL_W'(5) << WEIGHT_FRAC_BITS;
  localparam logic [FW_W-1:0]    MIN_W_RESET   = FW_W'(1) << WEIGHT_FRAC_BITS;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] lo;
    logic [OFFSET_BITS-1:0] hi;
  } zone_t;

  typedef zone_t [ZONE_MAX-1:0] zone_vec_t;

  // One closed fragment that is to be emitted, zone by zone.
  typedef struct packed {
    logic [OFFSET_BITS-1:0] frag_start;
    logic [OFFSET_BITS-1:0] frag_stop;
    logic [FW_W-1:0]        frag_weight;
    logic [POS_W-1:0]       hit_pos;
    logic [TERM_W-1:0]      best_term;
    zone_vec_t              zones;
    logic [ZC_W-1:0]        zone_count;
  } frag_rec_t;

endpackage

`default_nettype wire

/* design/sfs_front.sv */
// Front end of the snippet fragment selector: configuration registers,
// word window, open-fragment tracking and the close decision. Uses sfs_pkg.
`default_nettype none
`include "assert_macros.svh"

module sfs_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                accept,
  input  logic                                new_doc,
  input  logic [sfs_pkg::OFFSET_BITS-1:0]     word_start,
  input  logic [sfs_pkg::OFFSET_BITS-1:0]     word_end,
  input  logic [sfs_pkg::POS_W-1:0]           word_pos,
  input  logic                                is_hit,
  input  logic [sfs_pkg::TERM_W-1:0]          term_id,
  input  logic [sfs_pkg::WEIGHT_W-1:0]        term_weight,
  output logic                                rec_push,
  output sfs_pkg::frag_rec_t                  rec
);
  import sfs_pkg::*;

  // Configuration registers.
  logic [CTX_W-1:0]   context_words;
  logic [TOTAL_W-1:0] total_weight_limit;
  logic [FW_W-1:0]    min_fragment_weight;

  // Window of recent word starts, newest first.
  logic [OFFSET_BITS-1:0] window [WINDOW_DEPTH];
  logic [OFFSET_BITS-1:0] win_shift [WINDOW_DEPTH];

  // Fragment state.
  logic [FILL_W-1:0]      window_fill, window_fill_next, base_fill;
  logic [WREM_W-1:0]      words_remaining, words_remaining_next, base_wr;
  logic [EXT_W-1:0]       extension_count, extension_count_next, base_ext;
  logic                   previous_was_hit, previous_was_hit_next, base_prev;
  logic [OFFSET_BITS-1:0] frag_start, frag_start_next;
  logic [OFFSET_BITS-1:0] frag_stop, frag_stop_next;
  logic [FW_W-1:0]        frag_weight, frag_weight_next, base_fw;
  logic [TOTAL_W-1:0]     running_total, running_total_next, base_rt;
  logic [POS_W-1:0]       hit_pos, hit_pos_next;
  logic [TERM_W-1:0]      best_term, best_term_next;
  logic [WEIGHT_W-1:0]    best_weight, best_weight_next, base_bw;
  zone_vec_t              zones, zones_next;
  logic [ZC_W-1:0]        zone_count, zone_count_next, base_zc;

  // Intermediate values.
  logic [KEEP_W-1:0]      keep, keep_ctx, keep_fill, keep_m1;
  logic [WIN_IDX_W-1:0]   sel_idx;
  logic [FW_W:0]          fw_sum;
  logic [TOTAL_W:0]       rt_sum;
  logic                   close_frag;
  logic                   keep_frag;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      context_words       <= CONTEXT_RESET;
      total_weight_limit  <= LIMIT_RESET;
      min_fragment_weight <= MIN_W_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONTEXT_WORDS: context_words       <= cfg_data[CTX_W-1:0];
        CFG_TOTAL_LIMIT:   total_weight_limit  <= cfg_data[TOTAL_W-1:0];
        CFG_MIN_WEIGHT:    min_fragment_weight <= cfg_data[FW_W-1:0];
        default: ;
      endcase
    end
  end

  // The window as it stands once this word has been shifted in.
  always_comb begin
    win_shift[0] = word_start;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      win_shift[i] = window[i-1];
    end
  end

  // Per-word update of the open fragment and the close decision.
  always_comb begin
    // A new document starts from cleared state.
    base_fill = new_doc ? '0 : window_fill;
    base_wr   = new_doc ? '0 : words_remaining;
    base_ext  = new_doc ? '0 : extension_count;
    base_prev = new_doc ? 1'b0 : previous_was_hit;
    base_fw   = new_doc ? '0 : frag_weight;
    base_rt   = new_doc ? '0 : running_total;
    base_bw   = new_doc ? '0 : best_weight;
    base_zc   = new_doc ? '0 : zone_count;

    window_fill_next = (base_fill < FILL_W'(WINDOW_DEPTH)) ? base_fill + 1'b1 : base_fill;

    // The fragment opens at the oldest of the last keep words.
    keep_ctx  = KEEP_W'(context_words) + 1'b1;
    keep_fill = KEEP_W'(window_fill_next);
    keep      = (keep_ctx < keep_fill) ? keep_ctx : keep_fill;
    keep_m1   = keep - 1'b1;
    sel_idx   = keep_m1[WIN_IDX_W-1:0];

    words_remaining_next  = base_wr;
    extension_count_next  = base_ext;
    previous_was_hit_next = 1'b0;
    frag_start_next       = frag_start;
    frag_stop_next        = frag_stop;
    frag_weight_next      = base_fw;
    running_total_next    = base_rt;
    hit_pos_next          = hit_pos;
    best_term_next        = best_term;
    best_weight_next      = base_bw;
    zones_next            = zones;
    zone_count_next       = base_zc;
    fw_sum                = '0;
    rt_sum                = '0;
    close_frag            = 1'b0;
    keep_frag             = 1'b0;

    if (is_hit) begin
      if (base_wr == '0) begin
        // Open a fragment with a single zone.
        hit_pos_next     = word_pos;
        frag_start_next  = win_shift[sel_idx];
        frag_stop_next   = word_end;
        zones_next[0].lo = word_start;
        zones_next[0].hi = word_end;
        zone_count_next  = ZC_W'(1);
        best_term_next   = term_id;
        best_weight_next = term_weight;
      end else begin
        // Extend: grow the last zone on a run of hits, else add one.
        extension_count_next = base_ext + 1'b1;
        if (base_prev && (base_zc != '0)) begin
          for (int i = 0; i < ZONE_MAX; i++) begin
            if (ZC_W'(i) == base_zc - 1'b1) begin
              zones_next[i].hi = word_end;
            end
          end
        end else if (base_zc < ZC_W'(ZONE_MAX)) begin
          for (int i = 0; i < ZONE_MAX; i++) begin
            if (ZC_W'(i) == base_zc) begin
              zones_next[i].lo = word_start;
              zones_next[i].hi = word_end;
            end
          end
          zone_count_next = base_zc + 1'b1;
        end
        if (term_weight > base_bw) begin
          best_term_next   = term_id;
          best_weight_next = term_weight;
        end
      end
      previous_was_hit_next = 1'b1;
      fw_sum = {1'b0, base_fw} + (FW_W + 1)'(term_weight);
      frag_weight_next = fw_sum[FW_W] ? '1 : fw_sum[FW_W-1:0];
      words_remaining_next = WREM_W'(context_words) + 1'b1;
      // Too many extensions: close on this word.
      if (extension_count_next > EXT_LIMIT) begin
        words_remaining_next = WREM_W'(1);
        extension_count_next = '0;
      end
    end

    // Count down the trailing context; the fragment closes at zero.
    if (words_remaining_next != '0) begin
      words_remaining_next = words_remaining_next - 1'b1;
      frag_stop_next       = word_end;
      close_frag           = (words_remaining_next == '0);
    end

    rec.frag_start  = frag_start_next;
    rec.frag_stop   = frag_stop_next;
    rec.frag_weight = frag_weight_next;
    rec.hit_pos     = hit_pos_next;
    rec.best_term   = best_term_next;
    rec.zones       = zones_next;
    rec.zone_count  = zone_count_next;

    if (close_frag) begin
      keep_frag = (base_rt < total_weight_limit) ||
                  (frag_weight_next >= min_fragment_weight);
      rt_sum = {1'b0, base_rt} + (TOTAL_W + 1)'(frag_weight_next);
      running_total_next = rt_sum[TOTAL_W] ? '1 : rt_sum[TOTAL_W-1:0];
      frag_weight_next = '0;
      best_weight_next = '0;
      zone_count_next  = '0;
    end

    rec_push = accept && close_frag && keep_frag;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_fill      <= '0;
      words_remaining  <= '0;
      extension_count  <= '0;
      previous_was_hit <= 1'b0;
      frag_weight      <= '0;
      running_total    <= '0;
      best_weight      <= '0;
      zone_count       <= '0;
    end else if (accept) begin
      window_fill      <= window_fill_next;
      words_remaining  <= words_remaining_next;
      extension_count  <= extension_count_next;
      previous_was_hit <= previous_was_hit_next;
      frag_weight      <= frag_weight_next;
      running_total    <= running_total_next;
      best_weight      <= best_weight_next;
      zone_count       <= zone_count_next;
    end
  end

  // Payload state: window, fragment bounds, hit position, best term and zones.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        window[i] <= win_shift[i];
      end
      frag_start <= frag_start_next;
      frag_stop  <= frag_stop_next;
      hit_pos    <= hit_pos_next;
      best_term  <= best_term_next;
      zones      <= zones_next;
    end
  end

  // With no fragment open, its weight and best weight are clear.
  `ASSERT_IMPLIES(a_idle_frag_clear, clk, rst, words_remaining == '0, (frag_weight == '0) && (best_weight == '0))

endmodule

`default_nettype wire

/* design/sfs_queue.sv */
// Short register queue of fragment requests between front and back end.
// Uses sfs_pkg for the request record and the queue depth.
`default_nettype none
`include "assert_macros.svh"

module sfs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sfs_pkg::frag_rec_t rec_in,
  output logic               full,
  input  logic               pop,
  output sfs_pkg::frag_rec_t rec_out,
  output logic               empty
);
  import sfs_pkg::*;

  frag_rec_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rec_out = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Request storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= rec_in;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

/* design/sfs_back.sv */
// Back end of the snippet fragment selector: walks the zones of each
// queued fragment request and fills the result register. Uses sfs_pkg.
`default_nettype none
`include "assert_macros.svh"

module sfs_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  sfs_pkg::frag_rec_t              q_rec,
  output logic                            q_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [sfs_pkg::OFFSET_BITS-1:0] frag_start,
  output logic [sfs_pkg::OFFSET_BITS-1:0] frag_stop,
  output logic [sfs_pkg::FW_W-1:0]        frag_weight,
  output logic [sfs_pkg::POS_W-1:0]       first_hit_pos,
  output logic [sfs_pkg::TERM_W-1:0]      best_term,
  output logic [sfs_pkg::OFFSET_BITS-1:0] zone_start,
  output logic [sfs_pkg::OFFSET_BITS-1:0] zone_end,
  output logic                            last_zone
);
  import sfs_pkg::*;

  logic              out_valid;
  logic [ZC_W-1:0]   zone_idx;
  logic              load;
  logic              is_last;
  zone_t             cur_zone;

  assign empty   = !out_valid;
  assign load    = !q_empty && (!out_valid || pop);
  assign is_last = (zone_idx + 1'b1 == q_rec.zone_count);
  assign q_pop   = load && is_last;

  // Pick the zone under the walk index.
  always_comb begin
    cur_zone = q_rec.zones[0];
    for (int i = 1; i < ZONE_MAX; i++) begin
      if (zone_idx == ZC_W'(i)) begin
        cur_zone = q_rec.zones[i];
      end
    end
  end

  // Result valid flag and zone walk index.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      zone_idx  <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        zone_idx  <= is_last ? '0 : zone_idx + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      frag_start    <= q_rec.frag_start;
      frag_stop     <= q_rec.frag_stop;
      frag_weight   <= q_rec.frag_weight;
      first_hit_pos <= q_rec.hit_pos;
      best_term     <= q_rec.best_term;
      zone_start    <= cur_zone.lo;
      zone_end      <= cur_zone.hi;
      last_zone     <= is_last;
    end
  end

  // Every queued request holds at least one zone, and the walk stays inside it.
  `ASSERT_IMPLIES(a_rec_has_zone, clk, rst, !q_empty, q_rec.zone_count != '0)
  `ASSERT_IMPLIES(a_walk_in_range, clk, rst, !q_empty, zone_idx < q_rec.zone_count)

endmodule

`default_nettype wire

/* design/snippet_fragment_selector.sv */
// Snippet fragment selector top level: front end, request queue, back end.
// One word per cycle unless full; full rises only while four closed fragments wait.
// A closing fragment enters the queue, then its zones are loaded into the single
// result register of the back end one per cycle while pop is held.
// Synchronous reset clears all control state and loads the register defaults.
`default_nettype none

module snippet_fragment_selector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfs_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            new_doc,
  input  logic [sfs_pkg::OFFSET_BITS-1:0] word_start,
  input  logic [sfs_pkg::OFFSET_BITS-1:0] word_end,
  input  logic [sfs_pkg::POS_W-1:0]       word_pos,
  input  logic                            is_hit,
  input  logic [sfs_pkg::TERM_W-1:0]      term_id,
  input  logic [sfs_pkg::WEIGHT_W-1:0]    term_weight,
  output logic                            empty,
  input  logic                            pop,
  output logic [sfs_pkg::OFFSET_BITS-1:0] frag_start,
  output logic [sfs_pkg::OFFSET_BITS-1:0] frag_stop,
  output logic [sfs_pkg::FW_W-1:0]        frag_weight,
  output logic [sfs_pkg::POS_W-1:0]       first_hit_pos,
  output logic [sfs_pkg::TERM_W-1:0]      best_term,
  output logic [sfs_pkg::OFFSET_BITS-1:0] zone_start,
  output logic [sfs_pkg::OFFSET_BITS-1:0] zone_end,
  output logic                            last_zone
);
  import sfs_pkg::*;

  logic      accept;
  logic      rec_push;
  frag_rec_t rec_in;
  frag_rec_t q_rec;
  logic      q_full;
  logic      q_empty;
  logic      q_pop;

  // A word is taken whenever the request queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  sfs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .new_doc     (new_doc),
    .word_start  (word_start),
    .word_end    (word_end),
    .word_pos    (word_pos),
    .is_hit      (is_hit),
    .term_id     (term_id),
    .term_weight (term_weight),
    .rec_push    (rec_push),
    .rec         (rec_in)
  );

  sfs_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (rec_push),
    .rec_in  (rec_in),
    .full    (q_full),
    .pop     (q_pop),
    .rec_out (q_rec),
    .empty   (q_empty)
  );

  sfs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_rec         (q_rec),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .frag_start    (frag_start),
    .frag_stop     (frag_stop),
    .frag_weight   (frag_weight),
    .first_hit_pos (first_hit_pos),
    .best_term     (best_term),
    .zone_start    (zone_start),
    .zone_end      (zone_end),
    .last_zone     (last_zone)
  );

endmodule

`default_nettype wire

/* test/snippet_fragment_selector_tb.sv */
// Self-checking testbench for the snippet fragment selector: word requests go in, and each
// highlight zone request that comes out is checked against a behavioural fragment tracker.
// Depends on sfs_pkg and the snippet_fragment_selector RTL only.
`default_nettype none

module snippet_fragment_selector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfs_pkg::*;

  localparam int UNIT            = 1 << WEIGHT_FRAC_BITS;
  localparam int unsigned FRAG_WEIGHT_MAX = 5 * ((1 << WEIGHT_W) - 1);
  localparam int SETTLE_CYCLES   = 12;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASE_WORDS     = 18;

  // One word request and one highlight zone request.
  typedef struct {
    logic                   new_doc;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] stop;
    logic [POS_W-1:0]       pos;
    logic                   hit;
    logic [TERM_W-1:0]      term;
    logic [WEIGHT_W-1:0]    weight;
  } word_t;

  typedef struct {
    logic [OFFSET_BITS-1:0] frag_start;
    logic [OFFSET_BITS-1:0] frag_stop;
    logic [FW_W-1:0]        frag_weight;
    logic [POS_W-1:0]       hit_pos;
    logic [TERM_W-1:0]      best_term;
    logic [OFFSET_BITS-1:0] zone_lo;
    logic [OFFSET_BITS-1:0] zone_hi;
    logic                   last;
  } zone_result_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   push;
  logic                   full;
  logic                   new_doc;
  logic [OFFSET_BITS-1:0] word_start;
  logic [OFFSET_BITS-1:0] word_end;
  logic [POS_W-1:0]       word_pos;
  logic                   is_hit;
  logic [TERM_W-1:0]      term_id;
  logic [WEIGHT_W-1:0]    term_weight;
  logic                   empty;
  logic                   pop;
  logic [OFFSET_BITS-1:0] frag_start;
  logic [OFFSET_BITS-1:0] frag_stop;
  logic [FW_W-1:0]        frag_weight;
  logic [POS_W-1:0]       first_hit_pos;
  logic [TERM_W-1:0]      best_term;
  logic [OFFSET_BITS-1:0] zone_start;
  logic [OFFSET_BITS-1:0] zone_end;
  logic                   last_zone;

  snippet_fragment_selector DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .new_doc(new_doc), .word_start(word_start), .word_end(word_end), .word_pos(word_pos),
    .is_hit(is_hit), .term_id(term_id), .term_weight(term_weight),
    .empty(empty), .pop(pop),
    .frag_start(frag_start), .frag_stop(frag_stop), .frag_weight(frag_weight),
    .first_hit_pos(first_hit_pos), .best_term(best_term),
    .zone_start(zone_start), .zone_end(zone_end), .last_zone(last_zone)
  );

  always #6 clk = ~clk;

  // Tracker copy of the register file.
  logic [CTX_W-1:0]       ctx_words;
  logic [TOTAL_W-1:0]     weight_limit;
  logic [FW_W-1:0]        min_weight;

  // Tracker copy of the fragment state.
  logic [OFFSET_BITS-1:0] win_starts [WINDOW_DEPTH];
  int                     win_fill;
  int                     words_left;
  int                     ext_count;
  bit                     after_hit;
  logic [OFFSET_BITS-1:0] open_start;
  logic [OFFSET_BITS-1:0] open_stop;
  logic [FW_W-1:0]        open_weight;
  logic [TOTAL_W-1:0]     total_weight;
  logic [POS_W-1:0]       open_pos;
  logic [TERM_W-1:0]      open_term;
  logic [WEIGHT_W-1:0]    open_best;
  logic [OFFSET_BITS-1:0] zone_lo [ZONE_MAX];
  logic [OFFSET_BITS-1:0] zone_hi [ZONE_MAX];
  int                     zone_cnt;

  zone_result_t           expected_zones [$];

  // Document cursor used to build well-formed word streams.
  logic [OFFSET_BITS-1:0] text_pos;
  logic [POS_W-1:0]       term_pos;

  bit                     steady;
  int                     stall_left = 0;
  int                     cycle_count = 0;
  int                     words_sent = 0;
  int                     zones_checked = 0;
  int                     mismatch_count = 0;

  function automatic void clear_selector();
    int i;
    for (i = 0; i < WINDOW_DEPTH; i++) win_starts[i] = '0;
    for (i = 0; i < ZONE_MAX; i++) begin
      zone_lo[i] = '0;
      zone_hi[i] = '0;
    end
    win_fill     = 0;
    words_left   = 0;
    ext_count    = 0;
    after_hit    = 1'b0;
    open_start   = '0;
    open_stop    = '0;
    open_weight  = '0;
    total_weight = '0;
    open_pos     = '0;
    open_term    = '0;
    open_best    = '0;
    zone_cnt     = 0;
  endfunction

  function automatic void add_zone(logic [OFFSET_BITS-1:0] lo, logic [OFFSET_BITS-1:0] hi);
    if (zone_cnt < ZONE_MAX) begin
      zone_lo[zone_cnt] = lo;
      zone_hi[zone_cnt] = hi;
      zone_cnt++;
    end
  endfunction

  // Advance the fragment tracker by one accepted word and queue the zone requests it causes.
  function automatic void track_word(word_t w);
    int               i;
    int               keep;
    logic [FW_W:0]    wsum;
    logic [TOTAL_W:0] tsum;
    zone_result_t     z;
    if (w.new_doc) clear_selector();
    for (i = WINDOW_DEPTH - 1; i > 0; i--) win_starts[i] = win_starts[i-1];
    win_starts[0] = w.start;
    if (win_fill < WINDOW_DEPTH) win_fill++;
    keep = ctx_words + 1;
    if (keep > win_fill) keep = win_fill;

    if (w.hit) begin
      if (words_left == 0) begin
        // A fresh fragment reaches back over the context kept in the window.
        open_pos   = w.pos;
        open_start = win_starts[keep-1];
        open_stop  = w.stop;
        zone_cnt   = 0;
        add_zone(w.start, w.stop);
        open_term  = w.term;
        open_best  = w.weight;
      end else begin
        ext_count++;
        if (after_hit && zone_cnt > 0) zone_hi[zone_cnt-1] = w.stop;
        else add_zone(w.start, w.stop);
        if (w.weight > open_best) begin
          open_term = w.term;
          open_best = w.weight;
        end
      end
      after_hit   = 1'b1;
      wsum        = open_weight + w.weight;
      open_weight = (wsum > {FW_W{1'b1}}) ? {FW_W{1'b1}} : wsum[FW_W-1:0];
      words_left  = ctx_words + 1;
      if (ext_count > EXT_LIMIT) begin
        words_left = 1;
        ext_count  = 0;
      end
    end else begin
      after_hit = 1'b0;
    end

    // Count down the trailing context and close the fragment when it runs out.
    if (words_left != 0) begin
      words_left--;
      open_stop = w.stop;
      if (words_left == 0) begin
        if (total_weight < weight_limit || open_weight >= min_weight) begin
          for (i = 0; i < zone_cnt; i++) begin
            z.frag_start  = open_start;
            z.frag_stop   = open_stop;
            z.frag_weight = open_weight;
            z.hit_pos     = open_pos;
            z.best_term   = open_term;
            z.zone_lo     = zone_lo[i];
            z.zone_hi     = zone_hi[i];
            z.last        = (i + 1 == zone_cnt);
            expected_zones.insert(expected_zones.size(), z);
          end
        end
        tsum         = total_weight + open_weight;
        total_weight = (tsum > {TOTAL_W{1'b1}}) ? {TOTAL_W{1'b1}} : tsum[TOTAL_W-1:0];
        open_weight  = '0;
        open_best    = '0;
        zone_cnt     = 0;
      end
    end
  endfunction

  // Idle lengths: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return WEIGHT_W'($urandom_range(0, 2 * UNIT));
    if (r < 85) return WEIGHT_W'($urandom);
    if (r < 92) return WEIGHT_W'(UNIT);
    return (r < 96) ? '0 : '1;
  endfunction

  function automatic logic [TOTAL_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(UNIT, 8 * UNIT);
    endcase
  endfunction

  function automatic logic [FW_W-1:0] pick_min();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FW_W'(FRAG_WEIGHT_MAX);
      default: return FW_W'($urandom_range(0, 3 * UNIT));
    endcase
  endfunction

  function automatic word_t random_word();
    word_t w;
    w.new_doc = ($urandom_range(0, 9) == 0);
    w.start   = OFFSET_BITS'($urandom);
    w.stop    = OFFSET_BITS'($urandom);
    w.pos     = $urandom;
    w.hit     = 1'($urandom_range(0, 1));
    w.term    = TERM_W'($urandom);
    w.weight  = pick_weight();
    return w;
  endfunction

  // Present one word request and hold it until it is taken.
  task automatic send_word(word_t w);
    int gap;
    gap = idle_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    new_doc     <= w.new_doc;
    word_start  <= w.start;
    word_end    <= w.stop;
    word_pos    <= w.pos;
    is_hit      <= w.hit;
    term_id     <= w.term;
    term_weight <= w.weight;
    @(posedge clk);
    while (full) @(posedge clk);
    track_word(w);
    words_sent++;
  endtask

  task automatic start_document();
    text_pos = OFFSET_BITS'($urandom);
    term_pos = $urandom;
  endtask

  // Next word of the current document, a few bytes after the previous one.
  task automatic send_text_word(bit first, bit hit, logic [TERM_W-1:0] term,
                                logic [WEIGHT_W-1:0] weight);
    word_t w;
    w.new_doc = first;
    w.start   = text_pos + OFFSET_BITS'($urandom_range(1, 3));
    w.stop    = w.start + OFFSET_BITS'($urandom_range(1, 12));
    w.pos     = term_pos;
    w.hit     = hit;
    w.term    = term;
    w.weight  = weight;
    text_pos  = w.stop;
    term_pos++;
    send_word(w);
  endtask

  // Wait until every expected zone request has come out and the pipeline has drained.
  task automatic wait_for_quiet();
    push <= 1'b0;
    while (expected_zones.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      CFG_CONTEXT_WORDS: ctx_words    = value[CTX_W-1:0];
      CFG_TOTAL_LIMIT:   weight_limit = value[TOTAL_W-1:0];
      CFG_MIN_WEIGHT:    min_weight   = value[FW_W-1:0];
      default: ;
    endcase
  endtask

  // Reset values: merged and separate zones, carried extension count, five zones, a drop.
  task automatic test_directed_cases();
    int k;
    text_pos = 100;
    term_pos = 0;
    // Hit on the first word of a document, so the window holds a single start.
    send_text_word(1'b1, 1'b1, 16'd7, WEIGHT_W'(UNIT / 2));
    send_text_word(1'b0, 1'b1, 16'd9, WEIGHT_W'(2 * UNIT));
    send_text_word(1'b0, 1'b0, 16'd1, WEIGHT_W'(UNIT));
    // Equal weight later on: the earlier term stays the best one.
    send_text_word(1'b0, 1'b1, 16'd3, WEIGHT_W'(2 * UNIT));
    for (k = 0; k < 5; k++) send_text_word(1'b0, 1'b0, 16'd0, 24'd0);
    // Two extensions carried over from the last fragment, so the second one here closes it.
    send_text_word(1'b0, 1'b1, 16'd11, WEIGHT_W'(UNIT / 4));
    send_text_word(1'b0, 1'b0, 16'd0, 24'd0);
    send_text_word(1'b0, 1'b1, 16'd12, WEIGHT_W'(UNIT / 4));
    send_text_word(1'b0, 1'b1, 16'd13, WEIGHT_W'(UNIT / 4));
    // Five separate hit zones, the fifth closing the fragment at once.
    for (k = 0; k < 9; k++) begin
      send_text_word(1'b0, k % 2 == 0, TERM_W'(20 + k), WEIGHT_W'(UNIT / 4));
    end
    // Running total past the limit and a light fragment: dropped.
    send_text_word(1'b0, 1'b1, 16'd40, WEIGHT_W'(UNIT / 2));
    for (k = 0; k < 5; k++) send_text_word(1'b0, 1'b0, 16'd0, 24'd0);
  endtask

  // Registers at their extremes, fields at their extremes, and a fragment cut by a new document.
  task automatic test_register_extremes();
    word_t w;
    wait_for_quiet();
    write_register(CFG_CONTEXT_WORDS, 0);
    write_register(CFG_TOTAL_LIMIT, 0);
    write_register(CFG_MIN_WEIGHT, 0);
    w.new_doc = 1'b1;
    w.start   = '1;
    w.stop    = '1;
    w.pos     = '1;
    w.hit     = 1'b1;
    w.term    = '1;
    w.weight  = '1;
    send_word(w);
    w.new_doc = 1'b0;
    w.start   = '0;
    w.stop    = '0;
    w.pos     = '0;
    w.term    = '0;
    w.weight  = '0;
    send_word(w);
    w.start   = '1;
    w.hit     = 1'b0;
    send_word(w);

    wait_for_quiet();
    write_register(CFG_CONTEXT_WORDS, 15);
    write_register(CFG_TOTAL_LIMIT, '1);
    write_register(CFG_MIN_WEIGHT, FRAG_WEIGHT_MAX);
    start_document();
    send_text_word(1'b1, 1'b0, 16'd5, WEIGHT_W'(UNIT));
    send_text_word(1'b0, 1'b1, 16'd6, WEIGHT_W'(UNIT));
    send_text_word(1'b1, 1'b0, 16'd7, WEIGHT_W'(UNIT));
  endtask

  // Random documents under several register settings.
  task automatic test_random_documents();
    int phase;
    int sent;
    int doc_len;
    int hit_pct;
    int k;
    bit hit;
    for (phase = 0; phase < 5; phase++) begin
      wait_for_quiet();
      steady = (phase == 2);
      write_register(CFG_CONTEXT_WORDS, (phase == 0) ? 15 : (phase == 1) ? 0 :
                     $urandom_range(0, 15));
      write_register(CFG_TOTAL_LIMIT, pick_limit());
      write_register(CFG_MIN_WEIGHT, pick_min());
      sent = 0;
      while (sent < PHASE_WORDS) begin
        start_document();
        doc_len = (ctx_words == 15) ? $urandom_range(20, PHASE_WORDS) : $urandom_range(4, 24);
        hit_pct = $urandom_range(10, 60);
        hit = 1'b0;
        for (k = 0; k < doc_len && sent < PHASE_WORDS; k++) begin
          if ($urandom_range(0, 99) < 8) begin
            send_word(random_word());
          end else begin
            // Hits tend to come in runs, so zones get merged.
            hit = ($urandom_range(0, 99) < (hit ? hit_pct + 20 : hit_pct));
            send_text_word(k == 0, hit, TERM_W'($urandom), pick_weight());
          end
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  // Heaviest one-word fragments push the running total past a low limit.
  task automatic test_heavy_fragments();
    int k;
    wait_for_quiet();
    write_register(CFG_CONTEXT_WORDS, 0);
    write_register(CFG_TOTAL_LIMIT, UNIT);
    write_register(CFG_MIN_WEIGHT, FRAG_WEIGHT_MAX);
    start_document();
    // The first is kept below the limit; after it a single hit falls short of the minimum.
    for (k = 0; k < 4; k++) send_text_word(k == 0, 1'b1, TERM_W'($urandom), '1);
    wait_for_quiet();
    write_register(CFG_CONTEXT_WORDS, 1);
    // Five heaviest hits in a row reach the minimum exactly.
    for (k = 0; k < 5; k++) send_text_word(1'b0, 1'b1, TERM_W'($urandom), '1);
  endtask

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic check_zone_request();
    zone_result_t want;
    if (expected_zones.size() == 0) begin
      $display("%0t: zone request with none expected, actual zone 0x%0h..0x%0h",
               $time, zone_start, zone_end);
      mismatch_count++;
    end else begin
      want = expected_zones[0];
      expected_zones.delete(0);
      compare_field("frag_start", 32'(want.frag_start), 32'(frag_start));
      compare_field("frag_stop", 32'(want.frag_stop), 32'(frag_stop));
      compare_field("frag_weight", 32'(want.frag_weight), 32'(frag_weight));
      compare_field("first_hit_pos", want.hit_pos, first_hit_pos);
      compare_field("best_term", 32'(want.best_term), 32'(best_term));
      compare_field("zone_start", 32'(want.zone_lo), 32'(zone_start));
      compare_field("zone_end", 32'(want.zone_hi), 32'(zone_end));
      compare_field("last_zone", 32'(want.last), 32'(last_zone));
      zones_checked++;
    end
  endtask

  // Result side: check each taken request, then decide whether to stall.
  always @(posedge clk) begin
    cycle_count++;
    if (!rst && pop && !empty) check_zone_request();
    if (rst || stall_left != 0) begin
      pop <= 1'b0;
      if (!rst) stall_left--;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
    end
  end

  // Watchdog on the cycle count.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    push        = 1'b0;
    pop         = 1'b0;
    new_doc     = 1'b0;
    word_start  = '0;
    word_end    = '0;
    word_pos    = '0;
    is_hit      = 1'b0;
    term_id     = '0;
    term_weight = '0;
    steady      = 1'b0;
    ctx_words    = CONTEXT_RESET;
    weight_limit = LIMIT_RESET;
    min_weight   = MIN_W_RESET;
    clear_selector();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_register_extremes();
    test_random_documents();
    test_heavy_fragments();
    wait_for_quiet();

    $display("Sent %0d words and checked %0d zone requests, with context from 0 to 15 words,",
             words_sent, zones_checked);
    $display("both weight registers at their extremes and heavy fragments past a low limit.");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
